// ===== rtl/pdt_pkg.sv =====
// ----------------------------------------------------------------------------
// pdt_pkg
// Shared types and constants for the PCI presence diff table.
// ----------------------------------------------------------------------------
package pdt_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);

   localparam logic [15:0] VENDOR_NONE_HI = 16'hFFFF;
   localparam logic [15:0] VENDOR_NONE_LO = 16'h0000;

   localparam logic REQ_PROBE    = 1'b0;
   localparam logic REQ_END_SCAN = 1'b1;

   localparam logic KIND_ATTACH = 1'b0;
   localparam logic KIND_DETACH = 1'b1;

   typedef struct packed {
      logic [7:0]  bus;
      logic [4:0]  dev;
      logic [2:0]  fn;
   } loc_type;

   typedef struct packed {
      loc_type     loc;
      logic [15:0] product;
      logic [15:0] vendor;
      logic [7:0]  cls;
      logic [7:0]  subcls;
   } entry_type;

   typedef struct packed {
      logic        kind;
      entry_type   ent;
      logic        last;
   } event_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROBE_SCAN,
      ST_PROBE_HIT,
      ST_PROBE_ATTACH,
      ST_PROBE_MISS,
      ST_EOS_SCAN,
      ST_EOS_DONE
   } state_type;

endpackage

// ===== rtl/pci_presence_diff_table_unit.sv =====
// ----------------------------------------------------------------------------
// pci_presence_diff_table_unit
// Table of known PCI functions; turns probes and end-of-scan requests
// into attach and detach events.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken when start is high and busy is low. req_type 0 is a
//   probed function, req_type 1 closes a full scan cycle.
//   Each event appears on the rsp_ ports for one cycle with rsp_strobe high;
//   rsp_last marks the final event of a request. The receiver cannot stall.
//   Entries live in a one-read, one-write RAM of TABLE_ENTRIES rows with a
//   registered read; valid and seen marks are flip-flops.
//   Probe: the RAM is swept one row a cycle until the location hits;
//   events follow after the sweep ends. A probe with an absent vendor
//   leaves the unit idle.
//   End of scan: a full sweep, detaches going out as unseen entries are
//   found (one event is held back to set rsp_last).
//   No new request is taken until the last one is done, so the single RAM
//   read port serves one sweep at a time.
//   Reset clears valid and seen marks and the seeded flag; no events come
//   until the first end of scan has completed. RAM contents need no reset.
// ----------------------------------------------------------------------------
module pci_presence_diff_table_unit
   import pdt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_type,
   input  logic [7:0]  req_bus_number,
   input  logic [4:0]  req_device_number,
   input  logic [2:0]  req_function_number,
   input  logic [15:0] req_vendor_id,
   input  logic [15:0] req_device_id,
   input  logic [7:0]  req_class_code,
   input  logic [7:0]  req_subclass_code,
   output logic        rsp_strobe,
   output logic        rsp_event_kind,
   output logic [7:0]  rsp_event_bus,
   output logic [4:0]  rsp_event_device,
   output logic [2:0]  rsp_event_function,
   output logic [15:0] rsp_event_vendor,
   output logic [15:0] rsp_event_product,
   output logic [7:0]  rsp_event_class,
   output logic [7:0]  rsp_event_subclass,
   output logic        rsp_last
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   state_type state_ff, state_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic issue_ff, issue_in;
   logic chk_v_ff, chk_v_in;
   logic [IDX_W-1:0] chk_idx_ff, chk_idx_in;
   logic free_ok_ff, free_ok_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic [31:0] old_ident_ff, old_ident_in;
   logic pend_ff, pend_in;
   event_type pend_ev_ff, pend_ev_in;
   logic seeded_ff, seeded_in;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [TABLE_ENTRIES-1:0] seen_ff, seen_in;
   logic rsp_v_ff, rsp_v_in;
   event_type rsp_ev_ff, rsp_ev_in;
   entry_type req_ff, req_in;

   logic accept;
   logic ram_we;
   logic [IDX_W-1:0] ram_waddr;
   entry_type ram_wdata;
   logic [ENTRY_W-1:0] ram_rdata;
   entry_type rd_ent;

   pdt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (cnt_ff),
      .rdata (ram_rdata)
   );

   assign rd_ent = entry_type'(ram_rdata);
   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      issue_in     = issue_ff;
      chk_v_in     = 1'b0;
      chk_idx_in   = chk_idx_ff;
      free_ok_in   = free_ok_ff;
      free_idx_in  = free_idx_ff;
      hit_idx_in   = hit_idx_ff;
      old_ident_in = old_ident_ff;
      pend_in      = pend_ff;
      pend_ev_in   = pend_ev_ff;
      seeded_in    = seeded_ff;
      valid_in     = valid_ff;
      seen_in      = seen_ff;
      rsp_v_in     = 1'b0;
      rsp_ev_in    = rsp_ev_ff;
      req_in       = req_ff;
      ram_we       = 1'b0;
      ram_waddr    = free_idx_ff;
      ram_wdata    = req_ff;

      // sweep read issue, shared by both scan states
      if ((state_ff == ST_PROBE_SCAN || state_ff == ST_EOS_SCAN) && issue_ff) begin
         chk_v_in   = 1'b1;
         chk_idx_in = cnt_ff;
         cnt_in     = cnt_ff + 1'b1;
         if (cnt_ff == LAST_IDX) begin
            issue_in = 1'b0;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in.loc.bus  = req_bus_number;
               req_in.loc.dev  = req_device_number;
               req_in.loc.fn   = req_function_number;
               req_in.vendor   = req_vendor_id;
               req_in.product  = req_device_id;
               req_in.cls      = req_class_code;
               req_in.subcls   = req_subclass_code;
               cnt_in          = '0;
               issue_in        = 1'b1;
               free_ok_in      = 1'b0;
               pend_in         = 1'b0;
               if (req_type == REQ_END_SCAN) begin
                  state_in = ST_EOS_SCAN;
               end else if (req_vendor_id != VENDOR_NONE_HI &&
                            req_vendor_id != VENDOR_NONE_LO) begin
                  state_in = ST_PROBE_SCAN;
               end
            end
         end

         ST_PROBE_SCAN: begin
            if (chk_v_ff) begin
               if (!valid_ff[chk_idx_ff] && !free_ok_ff) begin
                  free_ok_in  = 1'b1;
                  free_idx_in = chk_idx_ff;
               end
               if (valid_ff[chk_idx_ff] && rd_ent.loc == req_ff.loc) begin
                  hit_idx_in   = chk_idx_ff;
                  old_ident_in = {rd_ent.product, rd_ent.vendor};
                  issue_in     = 1'b0;
                  chk_v_in     = 1'b0;
                  state_in     = ST_PROBE_HIT;
               end else if (chk_idx_ff == LAST_IDX) begin
                  state_in = ST_PROBE_MISS;
               end
            end
         end

         ST_PROBE_HIT: begin
            seen_in[hit_idx_ff] = 1'b1;
            state_in            = ST_IDLE;
            if (old_ident_ff != {req_ff.product, req_ff.vendor}) begin
               ram_we    = 1'b1;
               ram_waddr = hit_idx_ff;
               if (seeded_ff) begin
                  rsp_v_in              = 1'b1;
                  rsp_ev_in.kind        = KIND_DETACH;
                  rsp_ev_in.ent.loc     = req_ff.loc;
                  rsp_ev_in.ent.product = old_ident_ff[31:16];
                  rsp_ev_in.ent.vendor  = old_ident_ff[15:0];
                  rsp_ev_in.ent.cls     = '0;
                  rsp_ev_in.ent.subcls  = '0;
                  rsp_ev_in.last        = 1'b0;
                  state_in              = ST_PROBE_ATTACH;
               end
            end
         end

         ST_PROBE_ATTACH: begin
            rsp_v_in  = 1'b1;
            rsp_ev_in = '{kind: KIND_ATTACH, ent: req_ff, last: 1'b1};
            state_in  = ST_IDLE;
         end

         ST_PROBE_MISS: begin
            if (free_ok_ff) begin
               ram_we                = 1'b1;
               ram_waddr             = free_idx_ff;
               valid_in[free_idx_ff] = 1'b1;
               seen_in[free_idx_ff]  = 1'b1;
            end
            // table full still reports the attach
            if (seeded_ff) begin
               rsp_v_in  = 1'b1;
               rsp_ev_in = '{kind: KIND_ATTACH, ent: req_ff, last: 1'b1};
            end
            state_in = ST_IDLE;
         end

         ST_EOS_SCAN: begin
            if (chk_v_ff) begin
               if (valid_ff[chk_idx_ff] && !seen_ff[chk_idx_ff]) begin
                  valid_in[chk_idx_ff] = 1'b0;
                  if (seeded_ff) begin
                     // hold one detach back so the final one can carry last
                     if (pend_ff) begin
                        rsp_v_in  = 1'b1;
                        rsp_ev_in = pend_ev_ff;
                     end
                     pend_in    = 1'b1;
                     pend_ev_in = '{kind: KIND_DETACH, ent: rd_ent, last: 1'b0};
                  end
               end
               if (chk_idx_ff == LAST_IDX) begin
                  state_in = ST_EOS_DONE;
               end
            end
         end

         ST_EOS_DONE: begin
            if (pend_ff) begin
               rsp_v_in       = 1'b1;
               rsp_ev_in      = pend_ev_ff;
               rsp_ev_in.last = 1'b1;
            end
            pend_in   = 1'b0;
            seen_in   = '0;
            seeded_in = 1'b1;
            state_in  = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         issue_ff  <= 1'b0;
         chk_v_ff  <= 1'b0;
         pend_ff   <= 1'b0;
         seeded_ff <= 1'b0;
         valid_ff  <= '0;
         seen_ff   <= '0;
         rsp_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         issue_ff  <= issue_in;
         chk_v_ff  <= chk_v_in;
         pend_ff   <= pend_in;
         seeded_ff <= seeded_in;
         valid_ff  <= valid_in;
         seen_ff   <= seen_in;
         rsp_v_ff  <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      chk_idx_ff   <= chk_idx_in;
      free_ok_ff   <= free_ok_in;
      free_idx_ff  <= free_idx_in;
      hit_idx_ff   <= hit_idx_in;
      old_ident_ff <= old_ident_in;
      pend_ev_ff   <= pend_ev_in;
      rsp_ev_ff    <= rsp_ev_in;
      req_ff       <= req_in;
   end

   assign rsp_strobe         = rsp_v_ff;
   assign rsp_event_kind     = rsp_ev_ff.kind;
   assign rsp_event_bus      = rsp_ev_ff.ent.loc.bus;
   assign rsp_event_device   = rsp_ev_ff.ent.loc.dev;
   assign rsp_event_function = rsp_ev_ff.ent.loc.fn;
   assign rsp_event_vendor   = rsp_ev_ff.ent.vendor;
   assign rsp_event_product  = rsp_ev_ff.ent.product;
   assign rsp_event_class    = rsp_ev_ff.ent.cls;
   assign rsp_event_subclass = rsp_ev_ff.ent.subcls;
   assign rsp_last           = rsp_ev_ff.last;

endmodule

// ===== rtl/pdt_ram.sv =====
// ----------------------------------------------------------------------------
// pdt_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module pdt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
